// ----- src/rti_pkg.sv -----
package rti_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH = COORD_WIDTH + 1;
   localparam int NDOT_WIDTH = 2 * COORD_WIDTH + 2;
   localparam int NUM_WIDTH = COORD_WIDTH + DIFF_WIDTH + 2;
   localparam int PROD_WIDTH = 2 * DIFF_WIDTH;
   localparam int CROSS_WIDTH = PROD_WIDTH + 1;
   localparam int TERM_WIDTH = CROSS_WIDTH + COORD_WIDTH;
   localparam int EDGE_WIDTH = TERM_WIDTH + 2;
   localparam int DIV_WIDTH = (NUM_WIDTH > NDOT_WIDTH) ? NUM_WIDTH : NDOT_WIDTH;

   localparam int DIST_WIDTH = 31;
   localparam int INT_BITS = 15;
   localparam int FRAC_OUT_BITS = DIST_WIDTH - INT_BITS;
   localparam logic [DIST_WIDTH-1:0] DIST_MAX = {DIST_WIDTH{1'b1}};

   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_START_X = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_START_Y = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_START_Z = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DIR_X = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DIR_Y = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DIR_Z = 3'd5;

   localparam logic [2:0] OUT_HIT = 3'd0;
   localparam logic [2:0] OUT_CULLED = 3'd1;
   localparam logic [2:0] OUT_DEGENERATE = 3'd2;
   localparam logic [2:0] OUT_OUTSIDE = 3'd3;
   localparam logic [2:0] OUT_ZERO_DIV = 3'd4;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type v0_x;
      coord_type v0_y;
      coord_type v0_z;
      coord_type v1_x;
      coord_type v1_y;
      coord_type v1_z;
      coord_type v2_x;
      coord_type v2_y;
      coord_type v2_z;
      coord_type face_nx;
      coord_type face_ny;
      coord_type face_nz;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [DIST_WIDTH-1:0] hit_distance;
      logic [2:0]            outcome;
   } rsp_type;

   typedef struct packed {
      coord_type start_x;
      coord_type start_y;
      coord_type start_z;
      coord_type dir_x;
      coord_type dir_y;
      coord_type dir_z;
   } ray_type;

   typedef struct packed {
      logic [2:0]           outcome;
      logic [DIV_WIDTH-1:0] num_mag;
      logic [DIV_WIDTH-1:0] den_mag;
   } entry_type;

endpackage

// ----- src/rti_front.sv -----
module rti_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rti_pkg::req_type    req_data,
   input  rti_pkg::ray_type    ray,
   input  logic                push_full,
   output logic                push_valid,
   output rti_pkg::entry_type  push_data
);

   localparam int CW = rti_pkg::COORD_WIDTH;
   localparam int DW = rti_pkg::DIFF_WIDTH;
   localparam int PW = rti_pkg::PROD_WIDTH;
   localparam int XW = rti_pkg::CROSS_WIDTH;
   localparam int TW = rti_pkg::TERM_WIDTH;
   localparam int EW = rti_pkg::EDGE_WIDTH;
   localparam int NDW = rti_pkg::NDOT_WIDTH;
   localparam int NMW = rti_pkg::NUM_WIDTH;
   localparam int VW = rti_pkg::DIV_WIDTH;

   logic [4:0] valid_ff;
   logic       adv;

   logic signed [CW-1:0] dir [3];
   logic signed [CW-1:0] start [3];
   logic signed [CW-1:0] vtx [3][3];
   logic signed [CW-1:0] nrm [3];

   logic signed [DW-1:0]    diff_ff [3][3];
   logic signed [DW-1:0]    diff_in [3][3];
   logic signed [CW-1:0]    nrm_ff [3];

   logic signed [2*CW-1:0]  pnd_ff [3];
   logic signed [2*CW-1:0]  pnd_in [3];
   logic signed [CW+DW-1:0] pna_ff [3];
   logic signed [CW+DW-1:0] pna_in [3];
   logic signed [PW-1:0]    prod_ff [3][6];
   logic signed [PW-1:0]    prod_in [3][6];

   logic signed [NDW-1:0]   den3_ff, den3_in, den4_ff, den5_ff;
   logic signed [NMW-1:0]   num3_ff, num3_in, num4_ff, num5_ff;
   logic signed [XW-1:0]    cross_ff [3][3];
   logic signed [XW-1:0]    cross_in [3][3];
   logic signed [TW-1:0]    term_ff [3][3];
   logic signed [TW-1:0]    term_in [3][3];
   logic signed [EW-1:0]    edge_ff [3];
   logic signed [EW-1:0]    edge_in [3];

   logic any_pos, any_neg, all_zero, den_pos, num_pos, den_zero;
   logic [2:0] outcome;

   assign adv = !(valid_ff[4] && push_full);
   assign req_stall = !adv;

   always_comb begin
      dir[0] = ray.dir_x;
      dir[1] = ray.dir_y;
      dir[2] = ray.dir_z;
      start[0] = ray.start_x;
      start[1] = ray.start_y;
      start[2] = ray.start_z;
      vtx[0][0] = req_data.v0_x;
      vtx[0][1] = req_data.v0_y;
      vtx[0][2] = req_data.v0_z;
      vtx[1][0] = req_data.v1_x;
      vtx[1][1] = req_data.v1_y;
      vtx[1][2] = req_data.v1_z;
      vtx[2][0] = req_data.v2_x;
      vtx[2][1] = req_data.v2_y;
      vtx[2][2] = req_data.v2_z;
      nrm[0] = req_data.face_nx;
      nrm[1] = req_data.face_ny;
      nrm[2] = req_data.face_nz;
   end

   always_comb begin
      for (int v = 0; v < 3; v++) begin
         for (int k = 0; k < 3; k++) begin
            diff_in[v][k] = DW'(vtx[v][k]) - DW'(start[k]);
         end
      end
   end

   always_comb begin
      int p, q, k1, k2;
      for (int k = 0; k < 3; k++) begin
         pnd_in[k] = (2*CW)'(nrm_ff[k]) * (2*CW)'(dir[k]);
         pna_in[k] = (CW+DW)'(nrm_ff[k]) * (CW+DW)'(diff_ff[0][k]);
      end
      for (int j = 0; j < 3; j++) begin
         p = (j == 0) ? 2 : ((j == 1) ? 0 : 1);
         q = (j == 0) ? 1 : ((j == 1) ? 2 : 0);
         for (int k = 0; k < 3; k++) begin
            k1 = (k == 2) ? 0 : k + 1;
            k2 = (k == 0) ? 2 : k - 1;
            prod_in[j][2*k] = PW'(diff_ff[p][k1]) * PW'(diff_ff[q][k2]);
            prod_in[j][2*k+1] = PW'(diff_ff[p][k2]) * PW'(diff_ff[q][k1]);
         end
      end
   end

   always_comb begin
      den3_in = NDW'(pnd_ff[0]) + NDW'(pnd_ff[1]) + NDW'(pnd_ff[2]);
      num3_in = NMW'(pna_ff[0]) + NMW'(pna_ff[1]) + NMW'(pna_ff[2]);
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            cross_in[j][k] = XW'(prod_ff[j][2*k]) - XW'(prod_ff[j][2*k+1]);
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            term_in[j][k] = TW'(cross_ff[j][k]) * TW'(dir[k]);
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         edge_in[j] = EW'(term_ff[j][0]) + EW'(term_ff[j][1]) + EW'(term_ff[j][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         diff_ff <= diff_in;
         nrm_ff <= nrm;
         pnd_ff <= pnd_in;
         pna_ff <= pna_in;
         prod_ff <= prod_in;
         den3_ff <= den3_in;
         num3_ff <= num3_in;
         cross_ff <= cross_in;
         den4_ff <= den3_ff;
         num4_ff <= num3_ff;
         term_ff <= term_in;
         den5_ff <= den4_ff;
         num5_ff <= num4_ff;
         edge_ff <= edge_in;
      end
   end

   always_comb begin
      any_pos = 1'b0;
      any_neg = 1'b0;
      for (int j = 0; j < 3; j++) begin
         any_pos = any_pos || (!edge_ff[j][EW-1] && (edge_ff[j] != '0));
         any_neg = any_neg || edge_ff[j][EW-1];
      end
      all_zero = !any_pos && !any_neg;
      den_pos = !den5_ff[NDW-1] && (den5_ff != '0);
      num_pos = !num5_ff[NMW-1] && (num5_ff != '0);
      den_zero = (den5_ff == '0);
      if (den_pos || num_pos) begin
         outcome = rti_pkg::OUT_CULLED;
      end else if (all_zero) begin
         outcome = rti_pkg::OUT_DEGENERATE;
      end else if (any_pos && any_neg) begin
         outcome = rti_pkg::OUT_OUTSIDE;
      end else if (den_zero) begin
         outcome = rti_pkg::OUT_ZERO_DIV;
      end else begin
         outcome = rti_pkg::OUT_HIT;
      end
   end

   assign push_valid = valid_ff[4] && adv;
   assign push_data.outcome = outcome;
   assign push_data.num_mag = VW'($unsigned(NMW'(-num5_ff)));
   assign push_data.den_mag = VW'($unsigned(NDW'(-den5_ff)));

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[4] && push_full) |=> valid_ff[4])
      else $error("front result dropped while the queue was full");

   assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !push_full)
      else $error("front pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      (req_stall && valid_ff[0]) |=> valid_ff[0])
      else $error("front stage one lost a beat during a stall");

endmodule

// ----- src/rti_fifo.sv -----
module rti_fifo #(
   parameter int DEPTH = rti_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rti_pkg::entry_type  push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output rti_pkg::entry_type  pop_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   rti_pkg::entry_type store_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNTW-1:0] count_ff;

   assign full = (count_ff == CNTW'(DEPTH));
   assign empty = (count_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(DEPTH))
      else $error("queue count above depth");

   assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue popped while empty");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !empty)
      else $error("queue empty after a push");

endmodule

// ----- src/rti_div.sv -----
module rti_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  rti_pkg::entry_type  queue_data,
   output logic                queue_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rti_pkg::rsp_type    rsp_data
);

   localparam int VW = rti_pkg::DIV_WIDTH;
   localparam int QW = rti_pkg::DIST_WIDTH;
   localparam int IB = rti_pkg::INT_BITS;
   localparam int STAGES = QW + 1;

   logic [STAGES-1:0] valid_ff;
   logic              rsp_valid_ff;
   logic              adv;

   logic [VW-1:0] rem_ff [STAGES];
   logic [VW-1:0] rem_in [STAGES];
   logic [VW-1:0] den_ff [STAGES];
   logic [IB-1:0] low_ff [STAGES];
   logic [IB-1:0] low_in [STAGES];
   logic [QW-1:0] quo_ff [STAGES];
   logic [QW-1:0] quo_in [STAGES];
   logic [2:0]    out_ff [STAGES];
   logic          sat_ff [STAGES];
   logic          sat_in;

   rti_pkg::rsp_type rsp_ff, rsp_in;

   assign adv = !(rsp_valid_ff && rsp_stall);
   assign queue_pop = adv && !queue_empty;

   always_comb begin
      logic [VW:0] trial;
      rem_in[0] = queue_data.num_mag >> IB;
      low_in[0] = queue_data.num_mag[IB-1:0];
      quo_in[0] = '0;
      sat_in = (rem_in[0] >= queue_data.den_mag);
      for (int s = 1; s < STAGES; s++) begin
         trial = {rem_ff[s-1], low_ff[s-1][IB-1]};
         low_in[s] = {low_ff[s-1][IB-2:0], 1'b0};
         if (trial >= {1'b0, den_ff[s-1]}) begin
            rem_in[s] = VW'(trial - {1'b0, den_ff[s-1]});
            quo_in[s] = {quo_ff[s-1][QW-2:0], 1'b1};
         end else begin
            rem_in[s] = VW'(trial);
            quo_in[s] = {quo_ff[s-1][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= {valid_ff[STAGES-2:0], queue_pop};
         rsp_valid_ff <= valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= rem_in[0];
         low_ff[0] <= low_in[0];
         quo_ff[0] <= quo_in[0];
         den_ff[0] <= queue_data.den_mag;
         out_ff[0] <= queue_data.outcome;
         sat_ff[0] <= sat_in;
         for (int s = 1; s < STAGES; s++) begin
            rem_ff[s] <= rem_in[s];
            low_ff[s] <= low_in[s];
            quo_ff[s] <= quo_in[s];
            den_ff[s] <= den_ff[s-1];
            out_ff[s] <= out_ff[s-1];
            sat_ff[s] <= sat_ff[s-1];
         end
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_in.outcome = out_ff[STAGES-1];
      rsp_in.hit = (out_ff[STAGES-1] == rti_pkg::OUT_HIT);
      if (out_ff[STAGES-1] != rti_pkg::OUT_HIT) begin
         rsp_in.hit_distance = '0;
      end else if (sat_ff[STAGES-1]) begin
         rsp_in.hit_distance = rti_pkg::DIST_MAX;
      end else begin
         rsp_in.hit_distance = quo_ff[STAGES-1];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STAGES-1] && !adv) |=> valid_ff[STAGES-1])
      else $error("divider lost its last stage during a stall");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.hit_distance == '0))
      else $error("miss reported with a nonzero distance");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> (rsp_data.outcome == rti_pkg::OUT_HIT))
      else $error("hit flag and outcome disagree");

endmodule

// ----- src/ray_triangle_intersect_top.sv -----
// Ray against triangle test for a fixed ray held in six registers.
// The ray start and direction are written through the csr_ port (index 0 to
// 2 start x, y, z; 3 to 5 direction x, y, z); writes to other indexes are
// ignored. Write them only while no triangle is in flight.
// Triangles arrive on the req_ channel, one beat per triangle, and each gives
// exactly one beat on the rsp_ channel, in order: hit flag, outcome code and
// the distance along the ray in unsigned Q15.16.
// The block takes one triangle per cycle while req_stall is low. A beat passes
// from input to output through the front pipeline of products and sign
// tests, the queue, and the divider, which after a first saturation check
// settles one quotient bit per stage, then the output register.
// When the receiver stalls, the divider and output register hold; the front
// keeps accepting until the queue between them is full, then stalls req_.
// Reset clears the ray to zero and empties every pipeline stage and the queue.
module ray_triangle_intersect_top #(
   parameter int QUEUE_DEPTH = rti_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  rti_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output rti_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_we,
   input  logic [rti_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [rti_pkg::COORD_WIDTH-1:0]       csr_wdata
);

   rti_pkg::ray_type   ray_ff;
   rti_pkg::entry_type push_data, pop_data;
   logic push_valid, queue_full, queue_empty, queue_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         ray_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rti_pkg::REG_START_X: ray_ff.start_x <= csr_wdata;
            rti_pkg::REG_START_Y: ray_ff.start_y <= csr_wdata;
            rti_pkg::REG_START_Z: ray_ff.start_z <= csr_wdata;
            rti_pkg::REG_DIR_X: ray_ff.dir_x <= csr_wdata;
            rti_pkg::REG_DIR_Y: ray_ff.dir_y <= csr_wdata;
            rti_pkg::REG_DIR_Z: ray_ff.dir_z <= csr_wdata;
            default: ray_ff <= ray_ff;
         endcase
      end
   end

   rti_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .ray        (ray_ff),
      .push_full  (queue_full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   rti_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (queue_pop),
      .empty     (queue_empty),
      .pop_data  (pop_data)
   );

   rti_div u_div (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_data  (pop_data),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
